@@ rtl/core/swec_pkg.sv @@
// Shared types and constants of the sliding window event counter.
`default_nettype none

package swec_pkg;

  localparam int unsigned DEF_RING_DEPTH = 64;
  localparam int unsigned DEF_STAMP_BITS = 32;
  localparam int unsigned WIN_BITS       = 32;
  localparam logic [WIN_BITS-1:0] WIN_RESET = 32'd3000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the new stamp and its lower bound
    logic pop;     // drop the oldest stored stamp
    logic append;  // store the new stamp and post the result
  } swec_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic drop_ok;   // oldest stored stamp lies below the lower bound
    logic out_free;  // result register can take a new item this cycle
  } swec_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/swec_ctrl.sv @@
// Controller state machine of the sliding window event counter.
`default_nettype none

module swec_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire swec_pkg::swec_sts_t sts,
  output swec_pkg::swec_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_PRUNE = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PRUNE;
        end
      end
      ST_PRUNE: begin
        // pop stale stamps one a cycle, then append once the result slot is free
        if (sts.drop_ok) begin
          cmd.pop = 1'b1;
        end else if (sts.out_free) begin
          cmd.append = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/swec_dpath.sv @@
// Datapath of the sliding window event counter: stamp ring, pointers, result register.
`default_nettype none

module swec_dpath #(
  parameter int unsigned RING_DEPTH = swec_pkg::DEF_RING_DEPTH,
  parameter int unsigned STAMP_BITS = swec_pkg::DEF_STAMP_BITS,
  localparam int unsigned IDX_W = $clog2(RING_DEPTH),
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [swec_pkg::WIN_BITS-1:0] cfg_wr_data,
  input  wire logic [STAMP_BITS-1:0]         in_timestamp,
  input  wire swec_pkg::swec_cmd_t           cmd,
  output swec_pkg::swec_sts_t                sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [CNT_W-1:0]                   out_event_count,
  output logic                               out_overflow
);

  localparam int unsigned CMP_W =
    (STAMP_BITS > swec_pkg::WIN_BITS) ? STAMP_BITS : swec_pkg::WIN_BITS;
  localparam int unsigned SUM_W = IDX_W + 1;

  logic [swec_pkg::WIN_BITS-1:0] window_r;
  logic [STAMP_BITS-1:0]         stamp_r;
  logic [CMP_W-1:0]              lower_r;
  logic                          prune_en_r;
  logic [IDX_W-1:0]              oldest_r, oldest_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic                          out_valid_r;
  logic [CNT_W-1:0]              out_count_r;
  logic                          out_ovf_r;

  logic [STAMP_BITS-1:0] ring_mem [RING_DEPTH];
  logic [STAMP_BITS-1:0] rd_data_r;

  logic [CMP_W-1:0] t_ext, win_ext;
  logic [IDX_W-1:0] oldest_inc, wr_addr;
  logic [SUM_W-1:0] wr_sum;
  logic             full;

  assign t_ext   = CMP_W'(in_timestamp);
  assign win_ext = CMP_W'(window_r);
  assign full    = (count_r == CNT_W'(RING_DEPTH));

  assign oldest_inc = (oldest_r == IDX_W'(RING_DEPTH - 1)) ? '0 : oldest_r + 1'b1;

  // tail slot; when full it wraps onto the oldest slot, which is discarded
  assign wr_sum  = SUM_W'(oldest_r) + SUM_W'(count_r);
  assign wr_addr = (wr_sum >= SUM_W'(RING_DEPTH)) ?
                   IDX_W'(wr_sum - SUM_W'(RING_DEPTH)) : IDX_W'(wr_sum);

  always_comb begin
    oldest_nxt = oldest_r;
    count_nxt  = count_r;
    if (cmd.pop) begin
      oldest_nxt = oldest_inc;
      count_nxt  = count_r - 1'b1;
    end else if (cmd.append) begin
      if (full) begin
        oldest_nxt = oldest_inc;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // read port follows the next oldest slot, with write-through on a collision
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      ring_mem[wr_addr] <= stamp_r;
    end
    if (cmd.append && (wr_addr == oldest_nxt)) begin
      rd_data_r <= stamp_r;
    end else begin
      rd_data_r <= ring_mem[oldest_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stamp_r    <= in_timestamp;
      lower_r    <= t_ext - win_ext;
      prune_en_r <= (t_ext >= win_ext);
    end
    if (cmd.append) begin
      out_count_r <= full ? count_r : count_r + 1'b1;
      out_ovf_r   <= full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r    <= swec_pkg::WIN_RESET;
      oldest_r    <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
      oldest_r <= oldest_nxt;
      count_r  <= count_nxt;
      if (cmd.append) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.drop_ok  = (count_r != '0) && prune_en_r && (CMP_W'(rd_data_r) < lower_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid       = out_valid_r;
  assign out_event_count = out_count_r;
  assign out_overflow    = out_ovf_r;

endmodule

`default_nettype wire

@@ rtl/core/sliding_window_event_counter.sv @@
// Top level of the sliding window event counter.
`default_nettype none

// Counts events in a sliding time window. Each input item is an event
// timestamp; the block keeps up to RING_DEPTH recent stamps in a ring memory,
// drops from the oldest end every stamp below timestamp - window_length (only
// when timestamp >= window_length), appends the new stamp and returns how
// many stamps it holds: the events in [timestamp - window_length, timestamp].
// When the ring is still full after pruning, the oldest stamp is discarded,
// out_overflow is set and the count stays at RING_DEPTH. window_length resets
// to 3000 and is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block idles, which the block does not enforce. Each item is
// loaded, every stored stamp it drops is popped, then the item is appended:
// the ring's single read port examines one oldest stamp per cycle. Every stamp
// is dropped at most once. A finished result sits in an output register, so the
// next item is taken while it waits; a second result waits only if that register is full.
module sliding_window_event_counter #(
  parameter int unsigned RING_DEPTH = swec_pkg::DEF_RING_DEPTH,
  parameter int unsigned STAMP_BITS = swec_pkg::DEF_STAMP_BITS,
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [swec_pkg::WIN_BITS-1:0] cfg_wr_data,
  // event items
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [STAMP_BITS-1:0]         in_timestamp,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [CNT_W-1:0]                   out_event_count,
  output logic                               out_overflow
);

  swec_pkg::swec_cmd_t cmd;
  swec_pkg::swec_sts_t sts;

  // Sequence each item: load, pop stale stamps, append and post the result.
  swec_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold the ring, its pointers, the window register and the result register.
  swec_dpath #(
    .RING_DEPTH (RING_DEPTH),
    .STAMP_BITS (STAMP_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_timestamp    (in_timestamp),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_count (out_event_count),
    .out_overflow    (out_overflow)
  );

  // Never post a result over one that has not been taken.
  a_append_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> sts.out_free)
    else $error("result posted while output register still held an item");

  // Take one item at a time: input is not ready in the cycle after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item was in progress");

  // A result always counts its own event.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_event_count != '0))
    else $error("result with zero event count");

  // Overflow only comes with a saturated count.
  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_event_count == CNT_W'(RING_DEPTH)))
    else $error("overflow flagged below full depth");

endmodule

`default_nettype wire
